FILE: sv/uf2bwt_pkg.sv
// types and constants shared by the uf2 block write tracker
package uf2bwt_pkg;

  typedef struct packed {
    logic        kind;
    logic [31:0] magic_start0;
    logic [31:0] magic_start1;
    logic [31:0] magic_end;
    logic [31:0] flags;
    logic [31:0] img_offset;
    logic [8:0]  payload_size;
    logic [31:0] seq_no;
    logic [31:0] num_blocks;
    logic [31:0] block_family;
  } uf2bwt_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [8:0]  sector;
    logic [20:0] flash_offset;
    logic [8:0]  length;
    logic [2:0]  status;
    logic [6:0]  percent;
    logic [21:0] image_size;
    logic        last;
  } uf2bwt_res_t;

  typedef enum logic [1:0] {
    OP_NOT_UF2,
    OP_WRONG_FAM,
    OP_BLOCK,
    OP_COMPLETE
  } uf2bwt_op_e;

  typedef struct packed {
    uf2bwt_op_e  op;
    logic [31:0] target;
    logic [8:0]  len;
    logic [31:0] bno;
    logic [31:0] nblk;
    logic [31:0] fam;
  } uf2bwt_cmd_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_EVAL,
    BS_CLEAR,
    BS_WCHK,
    BS_WRD,
    BS_RANGE,
    BS_SEC,
    BS_SRD,
    BS_WRITE,
    BS_PCT,
    BS_PDIV,
    BS_STATUS
  } uf2bwt_state_e;

  localparam logic [1:0] KIND_ERASE  = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_WRITTEN   = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_NOT_UF2   = 3'd2;
  localparam logic [2:0] ST_WRONG_FAM = 3'd3;
  localparam logic [2:0] ST_RANGE_ERR = 3'd4;
  localparam logic [2:0] ST_COMMITTED = 3'd5;
  localparam logic [2:0] ST_REFUSED   = 3'd6;
  localparam logic [2:0] ST_DONE      = 3'd7;

  localparam logic [31:0] MAGIC0       = 32'h0A32_4655;
  localparam logic [31:0] MAGIC1       = 32'h9E5D_5157;
  localparam logic [31:0] MAGICE       = 32'h0AB1_6F30;
  localparam logic [31:0] FLAG_FAMILY  = 32'h0000_2000;
  localparam logic [31:0] FLAG_NOFLASH = 32'h0000_0001;

  localparam logic        CFG_FAMILY    = 1'b0;
  localparam logic        CFG_MAX_BYTES = 1'b1;
  localparam logic [21:0] MAX_BYTES_RST = 22'h20_0000;
  localparam logic [6:0]  PCT_FULL      = 7'd100;

endpackage

FILE: sv/uf2bwt_ram.sv
// generic single write, single read ram with registered read data
module uf2bwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/uf2bwt_div.sv
// restoring divider, one quotient bit per cycle
module uf2bwt_div #(
  parameter int DN = 22,
  parameter int DM = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DN-1:0] dividend_i,
  input  logic [DM-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DN-1:0] quot_o
);

  localparam int NW = $clog2(DN + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [DN-1:0] quo_q, quo_d;
  logic [DM-1:0] rem_q, rem_d;
  logic [DM-1:0] dvs_q, dvs_d;
  logic [DM:0]   trial;
  logic [DM:0]   diff;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quo_q[DN-1]};
    diff   = trial - {1'b0, dvs_q};
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DM-1:0];
        quo_d = {quo_q[DN-2:0], 1'b1};
      end else begin
        rem_d = trial[DM-1:0];
        quo_d = {quo_q[DN-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == NW'(DN - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: sv/uf2bwt_front.sv
// front end: configuration registers, header checks and command push
module uf2bwt_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  uf2bwt_pkg::uf2bwt_in_t  item_i,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [31:0]             cfg_data_i,
  input  logic                    q_full_i,
  output logic                    q_push_o,
  output uf2bwt_pkg::uf2bwt_cmd_t q_cmd_o,
  output logic [21:0]             max_bytes_o
);
  import uf2bwt_pkg::*;

  logic [31:0] family_q;
  logic [21:0] max_bytes_q;
  logic        magic_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      family_q    <= '0;
      max_bytes_q <= MAX_BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAMILY:    family_q    <= cfg_data_i;
        CFG_MAX_BYTES: max_bytes_q <= cfg_data_i[21:0];
        default:       family_q    <= family_q;
      endcase
    end
  end

  assign magic_ok = (item_i.magic_start0 == MAGIC0) && (item_i.magic_start1 == MAGIC1) &&
                    (item_i.magic_end == MAGICE) && ((item_i.flags & FLAG_FAMILY) != '0) &&
                    ((item_i.flags & FLAG_NOFLASH) == '0);

  always_comb begin
    q_cmd_o.target = item_i.img_offset;
    q_cmd_o.len    = item_i.payload_size;
    q_cmd_o.bno    = item_i.seq_no;
    q_cmd_o.nblk   = item_i.num_blocks;
    q_cmd_o.fam    = item_i.block_family;
    if (item_i.kind) begin
      q_cmd_o.op = OP_COMPLETE;
    end else if (!magic_ok) begin
      q_cmd_o.op = OP_NOT_UF2;
    end else if (item_i.block_family != family_q) begin
      q_cmd_o.op = OP_WRONG_FAM;
    end else begin
      q_cmd_o.op = OP_BLOCK;
    end
  end

  assign busy        = q_full_i;
  assign q_push_o    = start && !q_full_i;
  assign max_bytes_o = max_bytes_q;

endmodule

FILE: sv/uf2bwt_fifo.sv
// two entry command queue between front and back
module uf2bwt_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  uf2bwt_pkg::uf2bwt_cmd_t wdata_i,
  input  logic                    pop_i,
  output logic                    full_o,
  output logic                    valid_o,
  output uf2bwt_pkg::uf2bwt_cmd_t rdata_o
);
  import uf2bwt_pkg::*;

  uf2bwt_cmd_t mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        do_pop;

  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: sv/uf2bwt_back.sv
// back end: transfer state, block and sector maps, command and status words
module uf2bwt_back #(
  parameter int BLOCK_MAP_BITS = 8192,
  parameter int SECTOR_COUNT   = 512,
  parameter int SECTOR_BYTES   = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  uf2bwt_pkg::uf2bwt_cmd_t q_cmd_i,
  output logic                    q_pop_o,
  input  logic [21:0]             max_bytes_i,
  output logic                    res_valid_o,
  output uf2bwt_pkg::uf2bwt_res_t res_o
);
  import uf2bwt_pkg::*;

  localparam int EW   = $clog2(BLOCK_MAP_BITS);
  localparam int CW   = $clog2(BLOCK_MAP_BITS + 1);
  localparam int WW   = (BLOCK_MAP_BITS + 31) / 32;
  localparam int WAW  = (WW > 1) ? $clog2(WW) : 1;
  localparam int EWD  = (SECTOR_COUNT + 31) / 32;
  localparam int EAW  = (EWD > 1) ? $clog2(EWD) : 1;
  // sector size is a power of two, so the sector index is a plain shift
  localparam int SSH  = $clog2(SECTOR_BYTES);
  localparam int DN   = (CW + 7 > 22) ? CW + 7 : 22;
  localparam int DM   = EW;
  localparam int CLN  = (WW > EWD) ? WW : EWD;
  localparam int PW   = (CLN > 1) ? $clog2(CLN) : 1;

  uf2bwt_state_e state_q, state_d;
  uf2bwt_cmd_t   cmd_q, cmd_d;
  logic [2:0]    st_q, st_d;
  logic [21:0]   img_q, img_d;
  logic          active_q, active_d;
  logic          aborted_q, aborted_d;
  logic          commit_q, commit_d;
  logic [31:0]   run_fam_q, run_fam_d;
  logic [EW-1:0] exp_q, exp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [21:0]   max_end_q, max_end_d;
  logic [6:0]    pct_q, pct_d;
  logic [DN-1:0] sec_q, sec_d;
  logic [DN-1:0] esec_q, esec_d;
  logic [PW-1:0] ptr_q, ptr_d;

  logic           wm_we, em_we;
  logic [WAW-1:0] wm_waddr, wm_raddr;
  logic [EAW-1:0] em_waddr, em_raddr;
  logic [31:0]    wm_wdata, wm_rdata, em_wdata, em_rdata;

  logic          div_start, div_busy, div_done;
  logic [DN-1:0] div_dvd, div_quot;
  logic [DM-1:0] div_dvs;

  logic [32:0]   end33;
  logic [21:0]   endm1;
  logic [DN-1:0] cnt_ext, cnt_x100;
  logic          new_xfer, bno_in_map;
  logic [31:0]   wm_bit, em_bit;

  assign end33      = {1'b0, cmd_q.target} + 33'(cmd_q.len);
  assign endm1      = end33[21:0] - 22'd1;
  assign cnt_ext    = DN'(cnt_q);
  assign cnt_x100   = (cnt_ext << 6) + (cnt_ext << 5) + (cnt_ext << 2);
  assign bno_in_map = cmd_q.bno < 32'(BLOCK_MAP_BITS);
  assign new_xfer   = !active_q || (cmd_q.fam != run_fam_q) ||
                      ((cmd_q.nblk != '0) && (exp_q != '0) && (cmd_q.nblk != 32'(exp_q)));
  assign wm_bit     = 32'd1 << cmd_q.bno[4:0];
  assign em_bit     = 32'd1 << sec_q[4:0];
  assign wm_raddr   = WAW'(cmd_q.bno >> 5);
  assign em_raddr   = EAW'(sec_q >> 5);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    st_d      = st_q;
    img_d     = img_q;
    active_d  = active_q;
    aborted_d = aborted_q;
    commit_d  = commit_q;
    run_fam_d = run_fam_q;
    exp_d     = exp_q;
    cnt_d     = cnt_q;
    max_end_d = max_end_q;
    pct_d     = pct_q;
    sec_d     = sec_q;
    esec_d    = esec_q;
    ptr_d     = ptr_q;
    q_pop_o   = 1'b0;
    wm_we     = 1'b0;
    wm_waddr  = wm_raddr;
    wm_wdata  = wm_rdata | wm_bit;
    em_we     = 1'b0;
    em_waddr  = em_raddr;
    em_wdata  = em_rdata | em_bit;
    div_start = 1'b0;
    div_dvd   = cnt_x100;
    div_dvs   = exp_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (state_q)
      BS_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          state_d = BS_EVAL;
        end
      end
      BS_EVAL: begin
        img_d   = '0;
        st_d    = ST_WRITTEN;
        state_d = BS_STATUS;
        unique case (cmd_q.op)
          OP_NOT_UF2:   st_d = ST_NOT_UF2;
          OP_WRONG_FAM: st_d = ST_WRONG_FAM;
          OP_COMPLETE: begin
            if (aborted_q) begin
              st_d = ST_REFUSED;
            end else if (commit_q) begin
              st_d = ST_DONE;
            end else begin
              active_d = 1'b0;
              exp_d    = '0;
              if (max_end_q == '0) begin
                st_d = ST_REFUSED;
              end else begin
                commit_d = 1'b1;
                st_d     = ST_COMMITTED;
                img_d    = max_end_q;
              end
            end
          end
          default: begin
            state_d = BS_WCHK;
            if (new_xfer) begin
              cnt_d     = '0;
              exp_d     = '0;
              aborted_d = 1'b0;
              max_end_d = '0;
              pct_d     = '0;
              active_d  = 1'b1;
              run_fam_d = cmd_q.fam;
              ptr_d     = '0;
              state_d   = BS_CLEAR;
            end
            if ((cmd_q.nblk != '0) && (cmd_q.nblk < 32'(BLOCK_MAP_BITS))) begin
              exp_d = EW'(cmd_q.nblk);
            end
          end
        endcase
      end
      BS_CLEAR: begin
        // sweep both maps back to zero, one word of each per cycle until that map's words are all cleared
        wm_we    = ({1'b0, ptr_q} < (PW + 1)'(WW));
        wm_waddr = WAW'(ptr_q);
        wm_wdata = '0;
        em_we    = ({1'b0, ptr_q} < (PW + 1)'(EWD));
        em_waddr = EAW'(ptr_q);
        em_wdata = '0;
        ptr_d    = ptr_q + 1'b1;
        if ({1'b0, ptr_q} == (PW + 1)'(CLN - 1)) begin
          state_d = BS_WCHK;
        end
      end
      BS_WCHK: begin
        st_d = ST_WRITTEN;
        if ((exp_q != '0) && bno_in_map) begin
          state_d = BS_WRD;
        end else begin
          state_d = BS_RANGE;
        end
      end
      BS_WRD: begin
        if ((wm_rdata & wm_bit) != '0) begin
          st_d    = ST_DUPLICATE;
          state_d = BS_PCT;
        end else begin
          wm_we   = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          state_d = BS_RANGE;
        end
      end
      BS_RANGE: begin
        if (end33 > 33'(max_bytes_i)) begin
          aborted_d = 1'b1;
          active_d  = 1'b0;
          st_d      = ST_RANGE_ERR;
          state_d   = BS_STATUS;
        end else if (cmd_q.len == '0) begin
          state_d = BS_PCT;
        end else begin
          sec_d   = DN'(cmd_q.target[21:0] >> SSH);
          esec_d  = DN'(endm1 >> SSH);
          state_d = BS_SEC;
        end
      end
      BS_SEC: begin
        if (sec_q >= DN'(SECTOR_COUNT)) begin
          aborted_d = 1'b1;
          active_d  = 1'b0;
          st_d      = ST_RANGE_ERR;
          state_d   = BS_STATUS;
        end else begin
          state_d = BS_SRD;
        end
      end
      BS_SRD: begin
        if ((em_rdata & em_bit) == '0) begin
          em_we             = 1'b1;
          res_valid_o       = 1'b1;
          res_o.result_kind = KIND_ERASE;
          res_o.sector      = sec_q[8:0];
        end
        if (sec_q == esec_q) begin
          state_d = BS_WRITE;
        end else begin
          sec_d   = sec_q + 1'b1;
          state_d = BS_SEC;
        end
      end
      BS_WRITE: begin
        res_valid_o        = 1'b1;
        res_o.result_kind  = KIND_WRITE;
        res_o.flash_offset = cmd_q.target[20:0];
        res_o.length       = cmd_q.len;
        if (end33[21:0] > max_end_q) begin
          max_end_d = end33[21:0];
        end
        state_d = BS_PCT;
      end
      BS_PCT: begin
        if (exp_q != '0) begin
          div_start = 1'b1;
          state_d   = BS_PDIV;
        end else begin
          state_d = BS_STATUS;
        end
      end
      BS_PDIV: begin
        if (div_done) begin
          pct_d   = (div_quot > DN'(PCT_FULL)) ? PCT_FULL : div_quot[6:0];
          state_d = BS_STATUS;
        end
      end
      BS_STATUS: begin
        res_valid_o       = 1'b1;
        res_o.result_kind = KIND_STATUS;
        res_o.status      = st_q;
        res_o.percent     = pct_q;
        res_o.image_size  = img_q;
        res_o.last        = 1'b1;
        state_d           = BS_IDLE;
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BS_IDLE;
      active_q  <= 1'b0;
      aborted_q <= 1'b0;
      commit_q  <= 1'b0;
      run_fam_q <= '0;
      exp_q     <= '0;
      cnt_q     <= '0;
      max_end_q <= '0;
      pct_q     <= '0;
      ptr_q     <= '0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      aborted_q <= aborted_d;
      commit_q  <= commit_d;
      run_fam_q <= run_fam_d;
      exp_q     <= exp_d;
      cnt_q     <= cnt_d;
      max_end_q <= max_end_d;
      pct_q     <= pct_d;
      ptr_q     <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    st_q   <= st_d;
    img_q  <= img_d;
    sec_q  <= sec_d;
    esec_q <= esec_d;
  end

  uf2bwt_ram #(.WIDTH(32), .DEPTH(WW)) u_wmap (
    .clk_i   (clk_i),
    .we_i    (wm_we),
    .waddr_i (wm_waddr),
    .wdata_i (wm_wdata),
    .raddr_i (wm_raddr),
    .rdata_o (wm_rdata)
  );

  uf2bwt_ram #(.WIDTH(32), .DEPTH(EWD)) u_emap (
    .clk_i   (clk_i),
    .we_i    (em_we),
    .waddr_i (em_waddr),
    .wdata_i (em_wdata),
    .raddr_i (em_raddr),
    .rdata_o (em_rdata)
  );

  uf2bwt_div #(.DN(DN), .DM(DM)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.last) |=> (state_q == BS_IDLE))
    else $error("final word not followed by idle");

  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(exp_q) < 32'(BLOCK_MAP_BITS)) else $error("block count out of map");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pct_q <= PCT_FULL) else $error("percent above full");

  a_erase_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.result_kind == KIND_ERASE)) |-> active_q)
    else $error("erase outside a transfer");

endmodule

FILE: sv/uf2_block_write_tracker.sv
// uf2 block write tracker top level: front, command queue and back
// flow: a status-only item passes the queue, then the idle, evaluate and status states; a
// tracked block with a write also passes the map check, range, sector and write states
// and waits on the 22-bit percent divider; a new transfer adds a sweep that clears both maps
// throughput: one item at a time in the back, two more held in the queue; the receiver
// cannot stall; reset clears all transfer state, the maps are swept at each new transfer
module uf2_block_write_tracker #(
  parameter int BLOCK_MAP_BITS = 8192,
  parameter int SECTOR_COUNT   = 512,
  parameter int SECTOR_BYTES   = 4096
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  uf2bwt_pkg::uf2bwt_in_t  item_i,
  output logic                    result_valid_o,
  output uf2bwt_pkg::uf2bwt_res_t result_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [31:0]             cfg_data_i
);
  import uf2bwt_pkg::*;

  logic        q_full, q_push, q_pop, q_valid;
  uf2bwt_cmd_t q_wcmd, q_rcmd;
  logic [21:0] max_bytes;

  uf2bwt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_wcmd),
    .max_bytes_o (max_bytes)
  );

  uf2bwt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wcmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rdata_o (q_rcmd)
  );

  uf2bwt_back #(
    .BLOCK_MAP_BITS (BLOCK_MAP_BITS),
    .SECTOR_COUNT   (SECTOR_COUNT),
    .SECTOR_BYTES   (SECTOR_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_rcmd),
    .q_pop_o     (q_pop),
    .max_bytes_i (max_bytes),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

FILE: tb/sv/testbench.sv
// testbench for the uf2 block write tracker: directed table, then random blocks against a model
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import uf2bwt_pkg::*;

  localparam int MAP_BITS  = 8192;
  localparam int SEC_COUNT = 512;
  localparam int SEC_BYTES = 4096;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  uf2bwt_in_t  item_i = '0;
  logic        result_valid_o;
  uf2bwt_res_t result_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  uf2_block_write_tracker i_dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // tracker shadow state
  logic [31:0] fam_reg;
  logic [21:0] max_reg;
  bit          act, aborted, committed;
  int unsigned exp_blk, wr_cnt, end_max, pct;
  logic [31:0] run_fam;
  bit          wmap [MAP_BITS];
  bit          emap [SEC_COUNT];

  uf2bwt_res_t pending_words [$];
  int          errors = 0;
  bit          quiet = 1'b0;

  typedef struct {
    uf2bwt_in_t  it;
    bit          fixed;
    uf2bwt_res_t res;
  } row_t;

  function automatic uf2bwt_res_t mk(logic [1:0] k, int unsigned sec, int unsigned off,
                                     int unsigned len, logic [2:0] st, int unsigned p,
                                     int unsigned sz);
    uf2bwt_res_t r;
    r.result_kind = k;
    r.sector = sec[8:0];
    r.flash_offset = off[20:0];
    r.length = len[8:0];
    r.status = st;
    r.percent = p[6:0];
    r.image_size = sz[21:0];
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void clear_run();
    foreach (wmap[i]) wmap[i] = 1'b0;
    foreach (emap[i]) emap[i] = 1'b0;
    wr_cnt = 0; exp_blk = 0; aborted = 0; end_max = 0; pct = 0;
  endfunction

  task automatic model_reset();
    fam_reg = '0; max_reg = MAX_BYTES_RST; act = 0; committed = 0; run_fam = '0;
    clear_run();
  endtask

  // pushes the words one item causes
  task automatic predict_words(input uf2bwt_in_t it);
    uf2bwt_res_t w [$];
    bit fresh, ok;
    longint unsigned fin, s, e, p;
    fresh = 1;
    if (it.kind) begin
      if (aborted) w.push_back(mk(KIND_STATUS, 0, 0, 0, ST_REFUSED, pct, 0));
      else if (committed) w.push_back(mk(KIND_STATUS, 0, 0, 0, ST_DONE, pct, 0));
      else begin
        act = 0; exp_blk = 0;
        if (end_max == 0) w.push_back(mk(KIND_STATUS, 0, 0, 0, ST_REFUSED, pct, 0));
        else begin
          committed = 1;
          w.push_back(mk(KIND_STATUS, 0, 0, 0, ST_COMMITTED, pct, end_max));
        end
      end
    end else if (it.magic_start0 != MAGIC0 || it.magic_start1 != MAGIC1 ||
                 it.magic_end != MAGICE || (it.flags & FLAG_FAMILY) == 0 ||
                 (it.flags & FLAG_NOFLASH) != 0) begin
      w.push_back(mk(KIND_STATUS, 0, 0, 0, ST_NOT_UF2, pct, 0));
    end else if (it.block_family != fam_reg) begin
      w.push_back(mk(KIND_STATUS, 0, 0, 0, ST_WRONG_FAM, pct, 0));
    end else begin
      if (!act || it.block_family != run_fam ||
          (it.num_blocks > 0 && exp_blk > 0 && it.num_blocks != exp_blk)) begin
        clear_run();
        act = 1; run_fam = it.block_family;
      end
      if (it.num_blocks > 0 && it.num_blocks < MAP_BITS) exp_blk = it.num_blocks;
      if (exp_blk > 0 && it.seq_no < MAP_BITS) begin
        if (wmap[it.seq_no]) fresh = 0;
        else begin wmap[it.seq_no] = 1; wr_cnt++; end
      end
      ok = 1;
      if (fresh) begin
        fin = longint'(it.img_offset) + it.payload_size;
        ok = fin <= max_reg;
        if (ok && it.payload_size > 0) begin
          s = it.img_offset / SEC_BYTES;
          e = (fin - 1) / SEC_BYTES;
          for (longint unsigned i = s; i <= e; i++) begin
            if (i >= SEC_COUNT) begin ok = 0; break; end
            if (!emap[i]) begin
              emap[i] = 1;
              w.push_back(mk(KIND_ERASE, 32'(i), 0, 0, ST_WRITTEN, 0, 0));
            end
          end
          if (ok) begin
            w.push_back(mk(KIND_WRITE, 0, it.img_offset, it.payload_size, ST_WRITTEN, 0, 0));
            if (fin > end_max) end_max = 32'(fin);
          end
        end
        if (!ok) begin
          aborted = 1; act = 0;
          w.push_back(mk(KIND_STATUS, 0, 0, 0, ST_RANGE_ERR, pct, 0));
        end
      end
      if (ok) begin
        if (exp_blk > 0) begin
          p = (longint'(wr_cnt) * 100) / exp_blk;
          pct = p > 100 ? 100 : 32'(p);
        end
        w.push_back(mk(KIND_STATUS, 0, 0, 0, fresh ? ST_WRITTEN : ST_DUPLICATE, pct, 0));
      end
    end
    w[w.size()-1].last = 1'b1;
    foreach (w[i]) pending_words.push_back(w[i]);
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  // result checker
  always @(posedge clk_i) begin
    uf2bwt_res_t x;
    if (rst_ni && result_valid_o) begin
      if (pending_words.size() == 0) report("unexpected word", result_o, 0);
      else begin
        x = pending_words.pop_front();
        if (result_o.result_kind != x.result_kind) report("kind", result_o.result_kind, x.result_kind);
        if (result_o.sector != x.sector) report("sector", result_o.sector, x.sector);
        if (result_o.flash_offset != x.flash_offset)
          report("offset", result_o.flash_offset, x.flash_offset);
        if (result_o.length != x.length) report("length", result_o.length, x.length);
        if (result_o.status != x.status) report("status", result_o.status, x.status);
        if (result_o.percent != x.percent) report("percent", result_o.percent, x.percent);
        if (result_o.image_size != x.image_size)
          report("image_size", result_o.image_size, x.image_size);
        if (result_o.last != x.last) report("last", result_o.last, x.last);
      end
    end
  end

  function automatic uf2bwt_in_t blk(int unsigned addr, int unsigned len, int unsigned bno,
                                     int unsigned nb, int unsigned fam);
    uf2bwt_in_t it;
    it = '0;
    it.magic_start0 = MAGIC0; it.magic_start1 = MAGIC1; it.magic_end = MAGICE;
    it.flags = FLAG_FAMILY; it.img_offset = addr; it.payload_size = len[8:0];
    it.seq_no = bno; it.num_blocks = nb; it.block_family = fam;
    return it;
  endfunction

  function automatic uf2bwt_in_t done_evt();
    uf2bwt_in_t it;
    it = $urandom();
    it.kind = 1'b1;
    it.payload_size = $urandom_range(0, 476);
    return it;
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) @(posedge clk_i);
  endtask

  // start stays high between back to back words; callers that pause drop it
  task automatic send(input uf2bwt_in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      idle_cycles($urandom_range(1, 19));
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_words(it);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    idle_cycles(600);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_FAMILY) fam_reg = val;
    else max_reg = val[21:0];
  endtask

  // random block: mostly well formed and in one transfer
  function automatic uf2bwt_in_t rand_block(int unsigned nb, int unsigned fam);
    uf2bwt_in_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    it = blk($urandom_range(0, 40) * 256 + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 0),
             $urandom_range(0, 7) == 0 ? $urandom_range(0, 476) : 256,
             $urandom_range(0, nb + 1), nb, fam);
    if (r < 4) it.magic_start0 = $urandom();
    else if (r < 7) it.magic_start1 = $urandom();
    else if (r < 10) it.magic_end = $urandom();
    else if (r < 13) it.flags = $urandom();
    else if (r < 16) it.flags = $urandom() | FLAG_FAMILY | FLAG_NOFLASH;
    else if (r < 19) it.block_family = $urandom();
    else if (r < 22) it.img_offset = $urandom();
    else if (r < 24) it.num_blocks = $urandom();
    else if (r < 27) it.num_blocks = 0;
    else if (r < 29) it.seq_no = $urandom();
    else if (r < 31) it.img_offset = $urandom_range(0, 2097152);
    if (r > 95) begin
      it.flags = $urandom() | FLAG_FAMILY;
      it.flags[0] = 1'b0;
    end
    return it;
  endfunction

  row_t tbl [$];
  logic [31:0] fams [4] = '{32'h0, 32'hFFFF_FFFF, 32'hE48B_FF56, 32'h1234_5678};

  initial begin
    uf2bwt_in_t it;
    uf2bwt_in_t bad;
    int unsigned nb, fam;
    model_reset();
    idle_cycles(11);
    rst_ni <= 1'b1;
    idle_cycles(2);

    bad = blk(0, 256, 0, 4, 0);
    bad.magic_start0 = 32'h0;
    tbl.push_back('{bad, 1, mk(KIND_STATUS, 0, 0, 0, ST_NOT_UF2, 0, 0)});
    tbl.push_back('{done_evt(), 1, mk(KIND_STATUS, 0, 0, 0, ST_REFUSED, 0, 0)});
    tbl.push_back('{blk(0, 256, 0, 0, 32'h5), 1, mk(KIND_STATUS, 0, 0, 0, ST_WRONG_FAM, 0, 0)});
    tbl.push_back('{blk(0, 256, 0, 4, 0), 0, '0});
    tbl.push_back('{blk(0, 256, 0, 4, 0), 0, '0});
    tbl.push_back('{blk(4000, 476, 1, 4, 0), 0, '0});
    tbl.push_back('{blk(8192, 0, 2, 4, 0), 0, '0});
    tbl.push_back('{blk(0, 256, 9000, 4, 0), 0, '0});
    tbl.push_back('{blk(0, 256, 3, 4, 0), 0, '0});
    tbl.push_back('{blk(0, 256, 3, 4, 0), 0, '0});
    tbl.push_back('{done_evt(), 0, '0});
    tbl.push_back('{done_evt(), 1, mk(KIND_STATUS, 0, 0, 0, ST_DONE, 100, 0)});
    tbl.push_back('{blk(0, 256, 0, 0, 0), 0, '0});
    tbl.push_back('{blk(0, 256, 0, 32'hFFFF_FFFF, 0), 0, '0});
    tbl.push_back('{blk(2096896, 256, 1, 8191, 0), 0, '0});
    tbl.push_back('{blk(32'hFFFF_FF00, 476, 2, 8191, 0), 0, '0});
    tbl.push_back('{done_evt(), 1, mk(KIND_STATUS, 0, 0, 0, ST_REFUSED, 0, 0)});
    tbl.push_back('{blk(0, 256, 0, 2, 0), 0, '0});
    tbl.push_back('{blk(256, 256, 1, 2, 0), 0, '0});
    tbl.push_back('{blk(512, 256, 2, 2, 0), 0, '0});

    foreach (tbl[i]) begin
      send(tbl[i].it);
      if (tbl[i].fixed) begin
        tbl[i].res.last = 1'b1;
        if (pending_words[$] != tbl[i].res) report("table row", pending_words[$], tbl[i].res);
      end
    end
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      fam = fams[ph % 4];
      write_reg(CFG_FAMILY, fam);
      case (ph % 4)
        0: write_reg(CFG_MAX_BYTES, MAX_BYTES_RST);
        1: write_reg(CFG_MAX_BYTES, 0);
        2: write_reg(CFG_MAX_BYTES, 32'h3F_FFFF);
        default: write_reg(CFG_MAX_BYTES, $urandom_range(1000, 20000));
      endcase
      if (ph == 7) quiet = 1'b1;
      for (int n = 0; n < 50; n++) begin
        nb = (n % 25 == 0) ? $urandom_range(1, 12) : nb;
        if (n == 0) nb = $urandom_range(1, 12);
        if ($urandom_range(0, 19) == 0) send(done_evt());
        else begin
          it = rand_block(nb, fam);
          send(it);
        end
      end
      send(done_evt());
      drain();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

endmodule
